### rtl/utf8_stream_decoder_core_assert.svh
// assertion macros for the utf8 stream decoder, clocked on clk and held off in reset
`ifndef UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define UTF8SD_ASSERT_IMPL(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define UTF8SD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define UTF8SD_ASSERT_IMPL(lbl, prop)
`define UTF8SD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/utf8sd_pkg.sv
// shared types and constants for the utf8 stream decoder
`default_nettype none
package utf8sd_pkg;

    localparam logic [7:0] LEAD2_MARK = 8'hC0;
    localparam logic [7:0] LEAD3_MARK = 8'hE0;
    localparam logic [7:0] LEAD4_MARK = 8'hF0;
    localparam logic [7:0] CONT_MARK  = 8'h80;
    localparam int         CONT_SHIFT = 6;   // radix 0x40

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_ONE   = 2'd1;
    localparam logic [1:0] PEND_TWO   = 2'd2;
    localparam logic [1:0] PEND_THREE = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [31:0] code_point;
        logic        end_marker;
        logic        truncated;
    } result_t;

endpackage
`default_nettype wire

### rtl/utf8_stream_decoder_core.sv
// top level of the utf8 to 32-bit code point stream decoder
// a result appears on the master side in the cycle after its byte transaction
// throughput: one byte per cycle while s_tready is high; the sequence state and result register update together
// bytes that only open or continue a sequence give no result
// reset: rst_n asynchronous active low clears sequence state and the result valid
`default_nettype none
module utf8_stream_decoder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // byte_value
    input  wire logic        s_tlast,   // stream_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // code_point
    output logic             m_tlast,   // end_marker
    output logic             m_tuser    // truncated
);
    import utf8sd_pkg::*;

    result_t res;
    logic    load_ok;
    logic    fire;

    assign s_tready = load_ok;
    assign fire     = s_tvalid && load_ok;

    utf8sd_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .byte_value (s_tdata),
        .stream_end (s_tlast),
        .res        (res)
    );

    utf8sd_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

### rtl/utf8sd_decode.sv
// sequence state and combinational decode of one byte transaction
`default_nettype none
`include "utf8_stream_decoder_core_assert.svh"
module utf8sd_decode (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire logic [7:0]         byte_value,
    input  wire logic               stream_end,
    output utf8sd_pkg::result_t     res
);
    import utf8sd_pkg::*;

    logic [1:0]  pend_reg;
    logic [1:0]  pend_next;
    logic [31:0] part_reg;
    logic [31:0] part_next;
    logic [31:0] acc;

    // byte - 0x80 modulo 2^32 is the sign extension of byte with its top bit flipped
    assign acc = {part_reg[31-CONT_SHIFT:0], {CONT_SHIFT{1'b0}}}
               + {{25{~byte_value[7]}}, byte_value[6:0]};

    always_comb
    begin
        res       = '0;
        pend_next = pend_reg;
        part_next = part_reg;
        if (fire)
        begin
            if (stream_end)
            begin
                res.valid      = 1'b1;
                res.end_marker = 1'b1;
                res.truncated  = (pend_reg != PEND_NONE);
                pend_next      = PEND_NONE;
                part_next      = '0;
            end
            else if (pend_reg == PEND_NONE)
            begin
                if (byte_value < LEAD2_MARK)
                begin
                    res.valid      = 1'b1;
                    res.code_point = {24'd0, byte_value};
                end
                else if (byte_value < LEAD3_MARK)
                begin
                    part_next = {27'd0, byte_value[4:0]};
                    pend_next = PEND_ONE;
                end
                else if (byte_value < LEAD4_MARK)
                begin
                    part_next = {28'd0, byte_value[3:0]};
                    pend_next = PEND_TWO;
                end
                else
                begin
                    part_next = {28'd0, byte_value[3:0]};
                    pend_next = PEND_THREE;
                end
            end
            else
            begin
                pend_next = pend_reg - 2'd1;
                if (pend_reg == PEND_ONE)
                begin
                    res.valid      = 1'b1;
                    res.code_point = acc;
                    part_next      = '0;
                end
                else
                begin
                    part_next = acc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= PEND_NONE;
            part_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            part_reg <= part_next;
        end
    end

    `UTF8SD_ASSERT_NEXT(a_end_clears, fire && stream_end, pend_reg == PEND_NONE)
    `UTF8SD_ASSERT_IMPL(a_idle_zero, (pend_reg == PEND_NONE) |-> (part_reg == 32'd0))
    `UTF8SD_ASSERT_IMPL(a_end_zero_cp, (res.valid && res.end_marker) |-> (res.code_point == 32'd0))
    `UTF8SD_ASSERT_IMPL(a_trunc_on_end, (res.valid && res.truncated) |-> res.end_marker)

endmodule
`default_nettype wire

### rtl/utf8sd_out_reg.sv
// result register toward the master side
`default_nettype none
module utf8sd_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire utf8sd_pkg::result_t res,
    output logic                    load_ok,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [31:0]             m_tdata,    // code_point
    output logic                    m_tlast,    // end_marker
    output logic                    m_tuser     // truncated
);
    import utf8sd_pkg::*;

    logic        valid_reg;
    logic [31:0] cp_reg;
    logic        end_reg;
    logic        trunc_reg;

    // register frees up in the same cycle its result is taken
    assign load_ok = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ok)
        begin
            valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && res.valid)
        begin
            cp_reg    <= res.code_point;
            end_reg   <= res.end_marker;
            trunc_reg <= res.truncated;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = cp_reg;
    assign m_tlast  = end_reg;
    assign m_tuser  = trunc_reg;

endmodule
`default_nettype wire
